// ----- sv/cleb_pkg.sv -----
// Package for the cursor line editor buffer.
// Holds opcodes, status codes, default sizes and the controller command type.
// No dependencies.
package cleb_pkg;

   localparam int CAPACITY_DEFAULT = 1024;

   localparam int OP_W     = 3;
   localparam int CH_W     = 8;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [OP_W-1:0] OP_LEFT  = 3'd0;
   localparam logic [OP_W-1:0] OP_RIGHT = 3'd1;
   localparam logic [OP_W-1:0] OP_BACK  = 3'd2;
   localparam logic [OP_W-1:0] OP_INS   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd3;

   typedef struct packed {
      logic load;
      logic commit;
   } ctl_cmd_type;

endpackage

// ----- sv/cleb_ctrl.sv -----
// Controller state machine for the cursor line editor buffer.
// Runs the input and result handshakes and issues load and commit commands.
// Depends on cleb_pkg.
module cleb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cleb_pkg::ctl_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign cmd.load   = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit = (state_ff == S_EXEC) && out_free;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_load_enters_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_EXEC)
      else $error("load did not enter the execute state");

   a_commit_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && rsp_valid_ff && rsp_stall) |=> state_ff == S_EXEC)
      else $error("item finished while the result register was still held");
`endif

endmodule

// ----- sv/cleb_datapath.sv -----
// Datapath for the cursor line editor buffer: text store, gap counters,
// item registers and result registers. Acts on load and commit commands.
// Depends on cleb_pkg.
module cleb_datapath #(
   parameter int CAPACITY = cleb_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cleb_pkg::ctl_cmd_type             cmd,
   input  logic [cleb_pkg::OP_W-1:0]         req_op,
   input  logic [cleb_pkg::CH_W-1:0]         req_ch,
   input  logic [cleb_pkg::INDEX_W-1:0]      req_index,
   output logic [cleb_pkg::STATUS_W-1:0]     rsp_status,
   output logic [cleb_pkg::CH_W-1:0]         rsp_read_char,
   output logic [cleb_pkg::COUNT_W-1:0]      rsp_length,
   output logic [cleb_pkg::COUNT_W-1:0]      rsp_cursor
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > cleb_pkg::COUNT_W) ? CW : cleb_pkg::COUNT_W;
   localparam int PW = XW + 1;

   logic [cleb_pkg::CH_W-1:0] mem [CAPACITY];

   logic [CW-1:0] before_ff;
   logic [CW-1:0] before_in;
   logic [CW-1:0] after_ff;
   logic [CW-1:0] after_in;

   logic [cleb_pkg::OP_W-1:0]    op_ff;
   logic [cleb_pkg::CH_W-1:0]    ch_ff;
   logic [cleb_pkg::INDEX_W-1:0] idx_ff;
   logic [cleb_pkg::CH_W-1:0]    rdata_ff;

   logic [cleb_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [cleb_pkg::STATUS_W-1:0] rsp_status_in;
   logic [cleb_pkg::CH_W-1:0]     rsp_read_char_ff;
   logic [cleb_pkg::CH_W-1:0]     rsp_read_char_in;
   logic [cleb_pkg::COUNT_W-1:0]  rsp_length_ff;
   logic [cleb_pkg::COUNT_W-1:0]  rsp_cursor_ff;

   logic [PW-1:0] before_x;
   logic [PW-1:0] after_x;
   logic [PW-1:0] top_x;
   logic [PW-1:0] prev_x;
   logic [PW-1:0] gap_end_x;
   logic [PW-1:0] req_idx_x;
   logic [PW-1:0] pos_x;
   logic [PW-1:0] len_x;
   logic [PW-1:0] idx_x;
   logic [AW-1:0] rd_addr;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [cleb_pkg::CH_W-1:0] wr_data;

   logic [CW-1:0] len_in;
   logic [XW-1:0] len_out_x;
   logic [XW-1:0] cur_out_x;

   assign before_x  = PW'(before_ff);
   assign after_x   = PW'(after_ff);
   assign top_x     = PW'(CAPACITY) - after_x;
   assign prev_x    = before_x - PW'(1);
   assign gap_end_x = top_x - PW'(1);
   assign len_x     = before_x + after_x;
   assign req_idx_x = PW'(req_index);
   assign idx_x     = PW'(idx_ff);

   always_comb begin
      if (req_idx_x < before_x) begin
         pos_x = req_idx_x;
      end else begin
         pos_x = top_x + req_idx_x - before_x;
      end
   end

   always_comb begin
      case (req_op)
         cleb_pkg::OP_LEFT:  rd_addr = prev_x[AW-1:0];
         cleb_pkg::OP_RIGHT: rd_addr = top_x[AW-1:0];
         cleb_pkg::OP_READ:  rd_addr = pos_x[AW-1:0];
         default:            rd_addr = before_ff[AW-1:0];
      endcase
   end

   always_comb begin
      before_in        = before_ff;
      after_in         = after_ff;
      wr_en            = 1'b0;
      wr_addr          = before_ff[AW-1:0];
      wr_data          = ch_ff;
      rsp_status_in    = cleb_pkg::STAT_DONE;
      rsp_read_char_in = '0;
      case (op_ff)
         cleb_pkg::OP_LEFT: begin
            if (before_ff != '0) begin
               wr_en     = cmd.commit;
               wr_addr   = gap_end_x[AW-1:0];
               wr_data   = rdata_ff;
               before_in = before_ff - CW'(1);
               after_in  = after_ff + CW'(1);
            end else begin
               rsp_status_in = cleb_pkg::STAT_IGNORED;
            end
         end
         cleb_pkg::OP_RIGHT: begin
            if (after_ff != '0) begin
               wr_en     = cmd.commit;
               wr_data   = rdata_ff;
               before_in = before_ff + CW'(1);
               after_in  = after_ff - CW'(1);
            end else begin
               rsp_status_in = cleb_pkg::STAT_IGNORED;
            end
         end
         cleb_pkg::OP_BACK: begin
            if (before_ff != '0) begin
               before_in = before_ff - CW'(1);
            end else begin
               rsp_status_in = cleb_pkg::STAT_IGNORED;
            end
         end
         cleb_pkg::OP_INS: begin
            if (len_x < PW'(CAPACITY)) begin
               wr_en     = cmd.commit;
               before_in = before_ff + CW'(1);
            end else begin
               rsp_status_in = cleb_pkg::STAT_FULL;
            end
         end
         cleb_pkg::OP_READ: begin
            if (idx_x < len_x) begin
               rsp_read_char_in = rdata_ff;
            end else begin
               rsp_status_in = cleb_pkg::STAT_RANGE;
            end
         end
         default: begin
            rsp_status_in = cleb_pkg::STAT_IGNORED;
         end
      endcase
   end

   assign len_in    = CW'(before_in + after_in);
   assign len_out_x = XW'(len_in);
   assign cur_out_x = XW'(before_in);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.load) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         ch_ff  <= req_ch;
         idx_ff <= req_index;
      end
      if (cmd.commit) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_read_char_ff <= rsp_read_char_in;
         rsp_length_ff    <= len_out_x[cleb_pkg::COUNT_W-1:0];
         rsp_cursor_ff    <= cur_out_x[cleb_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         before_ff <= '0;
         after_ff  <= '0;
      end else if (cmd.commit) begin
         before_ff <= before_in;
         after_ff  <= after_in;
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_read_char = rsp_read_char_ff;
   assign rsp_length    = rsp_length_ff;
   assign rsp_cursor    = rsp_cursor_ff;

`ifndef ASSERT_OFF
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      len_x <= PW'(CAPACITY))
      else $error("text length exceeds capacity");

   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(before_ff) && $stable(after_ff))
      else $error("gap counters changed without a commit");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == cleb_pkg::OP_INS && rsp_status_in == cleb_pkg::STAT_DONE)
      |=> before_ff == $past(before_ff) + CW'(1))
      else $error("accepted insert did not advance the cursor");
`endif

endmodule

// ----- sv/cursor_line_editor_buffer.sv -----
// Top level of the cursor line editor buffer, a gap buffer with a cursor.
// Instantiates cleb_ctrl and cleb_datapath; depends on cleb_pkg.
//
// Each transfer on the request channel yields exactly one transfer on the
// response channel. In the accept cycle of an item the text store is read
// at the address the item needs; in the execute state that follows, the
// store is written, the gap counters are updated and the result register is
// loaded. The execute state waits while an earlier result is still held in
// the result register; the next request is accepted only after it ends, so
// a new item cannot start before the last one has been committed. The text
// store needs no clearing after reset; data read is only used once written.
module cursor_line_editor_buffer #(
   parameter int CAPACITY = cleb_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cleb_pkg::OP_W-1:0]     req_op,
   input  logic [cleb_pkg::CH_W-1:0]     req_ch,
   input  logic [cleb_pkg::INDEX_W-1:0]  req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cleb_pkg::STATUS_W-1:0] rsp_status,
   output logic [cleb_pkg::CH_W-1:0]     rsp_read_char,
   output logic [cleb_pkg::COUNT_W-1:0]  rsp_length,
   output logic [cleb_pkg::COUNT_W-1:0]  rsp_cursor
);

   cleb_pkg::ctl_cmd_type cmd;

   cleb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cleb_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .req_index     (req_index),
      .rsp_status    (rsp_status),
      .rsp_read_char (rsp_read_char),
      .rsp_length    (rsp_length),
      .rsp_cursor    (rsp_cursor)
   );

endmodule

// ----- tb/sv/gap_buffer_checker.sv -----
// Checker for the cursor line editor buffer: watches both channels, predicts each result
// from its own copy of the gap buffer and compares it with what the block returns.
// Depends on cleb_pkg.
module gap_buffer_checker
   import cleb_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CH_W-1:0]     req_ch,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [CH_W-1:0]     rsp_read_char,
   input  logic [COUNT_W-1:0]  rsp_length,
   input  logic [COUNT_W-1:0]  rsp_cursor,
   output int                  error_count,
   output int                  open_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CH_W-1:0]     read_char;
      logic [COUNT_W-1:0]  length;
      logic [COUNT_W-1:0]  cursor;
   } edit_result_type;

   logic [CH_W-1:0] text_mem [CAPACITY];
   int unsigned     left_len;
   int unsigned     right_len;
   edit_result_type expected_results[$];
   int unsigned     result_count;

   function automatic edit_result_type apply_edit(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                                  logic [INDEX_W-1:0] idx);
      edit_result_type r;
      int unsigned     top_pos;
      int unsigned     pos;
      r = '0;
      top_pos = CAPACITY - right_len;
      case (op)
         OP_LEFT: begin
            if (left_len > 0 && top_pos > 0) begin
               text_mem[top_pos-1] = text_mem[left_len-1];
               left_len--;
               right_len++;
            end else begin
               r.status = STAT_IGNORED;
            end
         end
         OP_RIGHT: begin
            if (right_len > 0 && top_pos < CAPACITY) begin
               text_mem[left_len] = text_mem[top_pos];
               left_len++;
               right_len--;
            end else begin
               r.status = STAT_IGNORED;
            end
         end
         OP_BACK: begin
            if (left_len > 0) begin
               left_len--;
            end else begin
               r.status = STAT_IGNORED;
            end
         end
         OP_INS: begin
            if (left_len + right_len < CAPACITY) begin
               text_mem[left_len] = ch;
               left_len++;
            end else begin
               r.status = STAT_FULL;
            end
         end
         OP_READ: begin
            if (idx < left_len + right_len) begin
               pos = (idx < left_len) ? idx : top_pos + (idx - left_len);
               if (pos < CAPACITY) begin
                  r.read_char = text_mem[pos];
               end
            end else begin
               r.status = STAT_RANGE;
            end
         end
         default: begin
            r.status = STAT_IGNORED;
         end
      endcase
      r.length = COUNT_W'(left_len + right_len);
      r.cursor = COUNT_W'(left_len);
      return r;
   endfunction

   always @(posedge clock) begin
      edit_result_type got;
      edit_result_type want;
      if (reset) begin
         left_len = 0;
         right_len = 0;
         expected_results.delete();
         error_count = 0;
         result_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_read_char, rsp_length, rsp_cursor};
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("result %0d: unexpected transfer, status %0d char %02h %s",
                           result_count, got.status, got.read_char,
                           $sformatf("length %0d cursor %0d", got.length, got.cursor));
               end
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.read_char !== want.read_char ||
                   got.length !== want.length || got.cursor !== want.cursor) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("result %0d: expected status %0d char %02h length %0d cursor %0d",
                              result_count, want.status, want.read_char, want.length,
                              want.cursor);
                     $display("result %0d: actual   status %0d char %02h length %0d cursor %0d",
                              result_count, got.status, got.read_char, got.length, got.cursor);
                  end
               end
            end
            result_count++;
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_edit(req_op, req_ch, req_index));
         end
      end
      open_count = expected_results.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the cursor line editor buffer: drives directed and random edit
// commands with random idling on both channels and reports the verdict.
// Depends on cleb_pkg, cursor_line_editor_buffer and gap_buffer_checker.
module tb;
   import cleb_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = OP_READ + 1'b1;
   localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [CH_W-1:0]     req_ch;
   logic [INDEX_W-1:0]  req_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [CH_W-1:0]     rsp_read_char;
   logic [COUNT_W-1:0]  rsp_length;
   logic [COUNT_W-1:0]  rsp_cursor;
   int                  error_count;
   int                  open_count;
   bit                  calm_tail;

   cursor_line_editor_buffer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_read_char (rsp_read_char),
      .rsp_length    (rsp_length),
      .rsp_cursor    (rsp_cursor)
   );

   gap_buffer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_read_char (rsp_read_char),
      .rsp_length    (rsp_length),
      .rsp_cursor    (rsp_cursor),
      .error_count   (error_count),
      .open_count    (open_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   always begin
      @(negedge clock);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_edit(logic [OP_W-1:0] op, logic [CH_W-1:0] ch, logic [INDEX_W-1:0] idx);
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_ch    <= ch;
      req_index <= idx;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_mixed(int insert_pct, int back_pct);
      int                 pick;
      int                 kind;
      logic [INDEX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 1) begin
         idx = INDEX_W'($urandom_range(0, 31));
      end else begin
         idx = INDEX_W'($urandom);
      end
      if (pick < insert_pct) begin
         send_edit(OP_INS, CH_W'($urandom), INDEX_W'($urandom));
      end else if (pick < insert_pct + back_pct) begin
         send_edit(OP_BACK, CH_W'($urandom), INDEX_W'($urandom));
      end else if (kind < 3) begin
         send_edit(OP_LEFT, CH_W'($urandom), INDEX_W'($urandom));
      end else if (kind < 6) begin
         send_edit(OP_RIGHT, CH_W'($urandom), INDEX_W'($urandom));
      end else if (kind < 9) begin
         send_edit(OP_READ, CH_W'($urandom), idx);
      end else begin
         send_edit(OP_W'(OP_SPARE_LO + $urandom_range(0, OP_SPARE_HI - OP_SPARE_LO)),
                   CH_W'($urandom), INDEX_W'($urandom));
      end
   endtask

   initial begin
      clock     = 1'b0;
      calm_tail = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_op    <= OP_LEFT;
      req_ch    <= '0;
      req_index <= '0;
      rsp_stall <= 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Boundary cases on an empty buffer, then a short edit across the gap.
      send_edit(OP_LEFT, '0, '0);
      send_edit(OP_RIGHT, '0, '0);
      send_edit(OP_BACK, '0, '0);
      send_edit(OP_READ, '0, '0);
      send_edit(OP_READ, '0, '1);
      for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
         send_edit(OP_W'(op), '1, '1);
      end
      send_edit(OP_INS, 8'h00, '0);
      send_edit(OP_INS, 8'hFF, '0);
      send_edit(OP_INS, 8'hA5, '0);
      for (int i = 0; i < 4; i++) begin
         send_edit(OP_READ, '0, INDEX_W'(i));
      end
      send_edit(OP_LEFT, '0, '0);
      send_edit(OP_LEFT, '0, '0);
      for (int i = 0; i < 3; i++) begin
         send_edit(OP_READ, '0, INDEX_W'(i));
      end
      send_edit(OP_RIGHT, '0, '0);
      send_edit(OP_BACK, '0, '0);
      send_edit(OP_RIGHT, '0, '0);
      send_edit(OP_RIGHT, '0, '0);
      send_edit(OP_INS, 8'h5A, '0);
      send_edit(OP_READ, '0, INDEX_W'(2));

      for (int i = 0; i < 40; i++) begin
         send_mixed(40, 15);
      end
      // Mostly inserts with no backspace, so the buffer fills and overflows.
      for (int i = 0; i < 1060; i++) begin
         if (i % 32 == 31) begin
            send_mixed(0, 0);
         end else begin
            send_edit(OP_INS, CH_W'($urandom), INDEX_W'($urandom));
         end
      end
      calm_tail = 1'b1;
      for (int i = 0; i < 100; i++) begin
         send_mixed(20, 40);
      end

      req_valid <= 1'b0;
      while (open_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/cleb_pkg.sv
sv/cleb_ctrl.sv
sv/cleb_datapath.sv
sv/cursor_line_editor_buffer.sv
tb/sv/gap_buffer_checker.sv
tb/sv/tb.sv
